// ===== rtl/core/ita_pkg.sv =====
// Shared types, constants and microcode table for the integer to ASCII converter.
`timescale 1ns / 1ps

package ita_pkg;

  // Value width; the divider works on a whole number of bytes.
  localparam int ValueWidth = 64;
  localparam int DivStep    = 8;
  localparam int MagW       = ((ValueWidth + DivStep - 1) / DivStep) * DivStep;
  localparam int DivCycles  = MagW / DivStep;
  localparam int DivCntW    = (DivCycles > 1) ? $clog2(DivCycles) : 1;
  localparam int CntW       = $clog2(ValueWidth + 1);
  localparam int PcW        = 4;

  localparam logic [4:0] RadixMin = 5'd2;
  localparam logic [4:0] RadixMax = 5'd16;
  localparam logic [4:0] RadixDec = 5'd10;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharNull  = 8'h00;

  localparam logic [7:0] DigitChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic        req_type;
    logic [63:0] value;
    logic [4:0]  radix;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic       radix_error;
  } rsp_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_WAIT, OP_NOP, OP_NEGATE, OP_DIV, OP_PUSH, OP_SIGN, OP_DIGIT, OP_ERROR
  } op_t;

  // Jump conditions; false falls through to pc + 1
  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_NO_ACCEPT, C_BAD_RADIX, C_DIV_BUSY, C_QUO_NZ, C_MORE
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
  } uword_t;

  localparam logic [PcW-1:0] PcWait  = 4'd0;
  localparam logic [PcW-1:0] PcCheck = 4'd1;
  localparam logic [PcW-1:0] PcNeg   = 4'd2;
  localparam logic [PcW-1:0] PcDiv   = 4'd3;
  localparam logic [PcW-1:0] PcPush  = 4'd4;
  localparam logic [PcW-1:0] PcSign  = 4'd5;
  localparam logic [PcW-1:0] PcDigit = 4'd6;
  localparam logic [PcW-1:0] PcDone  = 4'd7;
  localparam logic [PcW-1:0] PcError = 4'd8;

  // Microcode ROM
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: PcWait};
    unique case (pc)
      PcWait:  w = '{op: OP_WAIT,   cond: C_NO_ACCEPT, target: PcWait};
      PcCheck: w = '{op: OP_NOP,    cond: C_BAD_RADIX, target: PcError};
      PcNeg:   w = '{op: OP_NEGATE, cond: C_NEXT,      target: PcWait};
      PcDiv:   w = '{op: OP_DIV,    cond: C_DIV_BUSY,  target: PcDiv};
      PcPush:  w = '{op: OP_PUSH,   cond: C_QUO_NZ,    target: PcDiv};
      PcSign:  w = '{op: OP_SIGN,   cond: C_NEXT,      target: PcWait};
      PcDigit: w = '{op: OP_DIGIT,  cond: C_MORE,      target: PcDigit};
      PcDone:  w = '{op: OP_NOP,    cond: C_ALWAYS,    target: PcWait};
      PcError: w = '{op: OP_ERROR,  cond: C_ALWAYS,    target: PcWait};
      default: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: PcWait};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/integer_to_ascii_radix_top.sv =====
// Integer to ASCII converter top level: microcode sequencer and datapath.
`timescale 1ns / 1ps

// Converts one 64-bit value per item into lower-case ASCII digits in radix 2..16,
// most significant digit first, one character per output item, with last set on
// the final one. Signed decimal requests with the sign bit set print '-' and then
// the magnitude; other signed requests print the raw bit pattern as unsigned.
// A radix outside 2..16 gives one item with char_code 0, last and radix_error.
// Items are handled one at a time: req_stall is high whenever the sequencer is
// away from its wait word, from the accept until the conversion is through. The
// sequencer checks the radix and takes the magnitude; then for each digit the
// shared divider, which retires 8 quotient bits a cycle, runs and the remainder
// is pushed. The sign step follows whether or not it prints a '-', then one emit
// step per digit, which waits while the output is stalled. Worst case is radix 2
// at 64 digits.
// Control is a 9-word microcode ROM (ita_pkg::ucode) stepped by a program counter;
// digits collect on a 64-deep stack of 4-bit entries and are popped in order.
module integer_to_ascii_radix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  ita_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output ita_pkg::rsp_t rsp
);

  // sequencer
  logic [ita_pkg::PcW-1:0] pc;
  logic [ita_pkg::PcW-1:0] pc_next;
  ita_pkg::uword_t         uw;

  // datapath registers
  logic [ita_pkg::MagW-1:0]    mag;       // dividend, then quotient
  logic [3:0]                  rem;       // running remainder
  logic [4:0]                  radix_q;
  logic                        signed_q;
  logic                        neg;
  logic [ita_pkg::DivCntW-1:0] div_cnt;
  logic [3:0]                  stack [ita_pkg::ValueWidth];
  logic [ita_pkg::CntW-1:0]    cnt;       // digits on the stack

  logic                        out_free;
  logic                        emit;
  logic                        hold;
  logic                        cond_true;
  logic                        bad_radix;
  logic [ita_pkg::MagW-1:0]    div_mag_next;
  logic [3:0]                  div_rem_next;
  logic [ita_pkg::MagW-1:0]    mag_neg;
  logic                        neg_take;
  ita_pkg::rsp_t               rsp_next;

  assign uw        = ita_pkg::ucode(pc);
  assign req_stall = (pc != ita_pkg::PcWait);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign bad_radix = (radix_q < ita_pkg::RadixMin) || (radix_q > ita_pkg::RadixMax);
  assign neg_take  = signed_q && (radix_q == ita_pkg::RadixDec) &&
                     mag[ita_pkg::ValueWidth-1];

  // Eight restoring division steps per cycle; remainder stays below radix.
  always_comb begin
    logic [ita_pkg::MagW-1:0] d;
    logic [4:0]               r;
    logic [4:0]               t;
    d = mag;
    r = {1'b0, rem};
    for (int k = 0; k < ita_pkg::DivStep; k++) begin
      t = {r[3:0], d[ita_pkg::MagW-1]};
      d = {d[ita_pkg::MagW-2:0], 1'b0};
      if (t >= radix_q) begin
        r    = t - radix_q;
        d[0] = 1'b1;
      end else begin
        r = t;
      end
    end
    div_mag_next = d;
    div_rem_next = r[3:0];
  end

  // Two's-complement magnitude over the value width only.
  always_comb begin
    mag_neg = '0;
    mag_neg[ita_pkg::ValueWidth-1:0] = ~mag[ita_pkg::ValueWidth-1:0] + 1'b1;
  end

  // Output steps wait for a free output register.
  always_comb begin
    emit     = 1'b0;
    rsp_next = '{char_code: ita_pkg::CharNull, last: 1'b0, radix_error: 1'b0};
    unique case (uw.op)
      ita_pkg::OP_SIGN: begin
        emit     = neg;
        rsp_next = '{char_code: ita_pkg::CharMinus, last: 1'b0, radix_error: 1'b0};
      end
      ita_pkg::OP_DIGIT: begin
        emit     = 1'b1;
        rsp_next = '{char_code: ita_pkg::DigitChars[stack[0]],
                     last: (cnt == ita_pkg::CntW'(1)), radix_error: 1'b0};
      end
      ita_pkg::OP_ERROR: begin
        emit     = 1'b1;
        rsp_next = '{char_code: ita_pkg::CharNull, last: 1'b1, radix_error: 1'b1};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign hold = emit && !out_free;

  always_comb begin
    unique case (uw.cond)
      ita_pkg::C_NEXT:      cond_true = 1'b0;
      ita_pkg::C_ALWAYS:    cond_true = 1'b1;
      ita_pkg::C_NO_ACCEPT: cond_true = !req_valid;
      ita_pkg::C_BAD_RADIX: cond_true = bad_radix;
      ita_pkg::C_DIV_BUSY:  cond_true = (div_cnt != ita_pkg::DivCntW'(ita_pkg::DivCycles - 1));
      ita_pkg::C_QUO_NZ:    cond_true = (mag != '0);
      ita_pkg::C_MORE:      cond_true = (cnt != ita_pkg::CntW'(1));
      default:              cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ita_pkg::PcWait;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (emit && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end

      unique case (uw.op)
        ita_pkg::OP_WAIT: begin
          if (req_valid) begin
            mag      <= ita_pkg::MagW'(req.value[ita_pkg::ValueWidth-1:0]);
            radix_q  <= req.radix;
            signed_q <= req.req_type;
            neg      <= 1'b0;
            cnt      <= '0;
          end
        end
        ita_pkg::OP_NEGATE: begin
          if (neg_take) begin
            mag <= mag_neg;
            neg <= 1'b1;
          end
          rem     <= '0;
          div_cnt <= '0;
        end
        ita_pkg::OP_DIV: begin
          mag     <= div_mag_next;
          rem     <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
        end
        ita_pkg::OP_PUSH: begin
          for (int i = ita_pkg::ValueWidth - 1; i > 0; i--) begin
            stack[i] <= stack[i-1];
          end
          stack[0] <= rem;
          cnt      <= cnt + 1'b1;
          rem      <= '0;
          div_cnt  <= '0;
        end
        ita_pkg::OP_DIGIT: begin
          if (out_free) begin
            for (int i = 0; i < ita_pkg::ValueWidth - 1; i++) begin
              stack[i] <= stack[i+1];
            end
            cnt <= cnt - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ita_check.sv =====
// Port-level checker for the integer to ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module ita_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ita_pkg::rsp_t rsp
);

  // one item in flight: an accept closes the input channel next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input accepted back to back");

  // error items carry no character and end the conversion
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.radix_error |-> rsp.last && (rsp.char_code == ita_pkg::CharNull))
    else $error("malformed radix error item");

  // a '-' is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.char_code == ita_pkg::CharMinus) |-> !rsp.last)
    else $error("sign emitted as last character");

  // stalled output item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled output item changed");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_ascii_radix_top ita_check u_ita_check (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for integer_to_ascii_radix_top: directed table plus random items.
`timescale 1ns / 1ps
module tb;

  // Radix 2 with all 64 bits set is the slowest item, with 64 characters that may
  // each be stalled. The limit covers every item at that cost, several times over.
  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = 100;
  localparam int RandomItems  = 385;
  localparam int ShowLimit    = 10;

  // How a directed row gets its expected characters
  typedef enum logic [1:0] {
    ROW_MODEL,  // worked out by the predictor
    ROW_TEXT,   // typed in as a string
    ROW_ERROR   // one radix error character
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    ita_pkg::req_t rq;
    string         txt;
  } stim_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  ita_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  ita_pkg::rsp_t rsp;

  ita_pkg::rsp_t pending_chars[$];  // characters still owed by the converter, oldest first
  stim_row_t     dir_rows[$];
  bit            calm        = 1'b0;  // no idling on either side while set
  int            fail_count  = 0;
  int            cycle_count = 0;

  integer_to_ascii_radix_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** integer_to_ascii_radix_top: FAILED **");
      $finish;
    end
  end

  // Output side stalls about a third of the time, never while calm.
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
  end

  function automatic void report_fail(input string msg);
    fail_count++;
    if (fail_count <= ShowLimit) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: digits of the value in the requested radix, MSD first.
  // Only signed decimal with the sign bit set prints '-' and the magnitude;
  // the negation wraps, so the most negative value keeps its exact magnitude.
  // ---------------------------------------------------------------------------
  function automatic void predict_chars(input ita_pkg::req_t rq);
    logic [63:0]   mag;
    logic [4:0]    base;
    logic [3:0]    digs [64];
    int            nd;
    ita_pkg::rsp_t c;
    base = rq.radix;
    if (base < ita_pkg::RadixMin || base > ita_pkg::RadixMax) begin
      c = '{char_code: ita_pkg::CharNull, last: 1'b1, radix_error: 1'b1};
      pending_chars.push_back(c);
      return;
    end
    mag = rq.value;
    if (rq.req_type && base == ita_pkg::RadixDec && mag[63]) begin
      mag = -mag;
      c = '{char_code: ita_pkg::CharMinus, last: 1'b0, radix_error: 1'b0};
      pending_chars.push_back(c);
    end
    // zero still yields one '0' digit
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 64'(base));
      mag      = mag / 64'(base);
      nd++;
    end while (mag != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      c.char_code   = (digs[i] < 4'd10) ? "0" + digs[i] : "a" + (digs[i] - 4'd10);
      c.last        = (i == 0);
      c.radix_error = 1'b0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void queue_text(input string txt);
    ita_pkg::rsp_t c;
    for (int i = 0; i < txt.len(); i++) begin
      c.char_code   = txt[i];
      c.last        = (i == txt.len() - 1);
      c.radix_error = 1'b0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic sgn,
                                  input logic [63:0] val, input logic [4:0] rdx,
                                  input string txt);
    stim_row_t r;
    r.kind = kind;
    r.rq   = '{req_type: sgn, value: val, radix: rdx};
    r.txt  = txt;
    dir_rows.push_back(r);
  endfunction

  // Random request: mostly valid radixes, a share of bad ones, extra weight on
  // signed decimal, and values of every digit count.
  function automatic ita_pkg::req_t make_req();
    ita_pkg::req_t rq;
    int            sel;
    int            r;
    logic [63:0]   v;
    sel         = $urandom_range(0, 99);
    rq.req_type = 1'($urandom_range(0, 1));
    if (sel < 8) begin
      r        = $urandom_range(0, 16);
      rq.radix = (r < 2) ? 5'(r) : 5'(r + 15);  // 0, 1 or 17..31
    end else if (sel < 22) begin
      rq.radix    = ita_pkg::RadixDec;
      rq.req_type = 1'b1;
    end else begin
      rq.radix = 5'($urandom_range(2, 16));
    end
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: ;
      2:    v = v >> $urandom_range(1, 63);
      3:    v = v & 64'hff;
      4:    v = ~64'd0 - 64'($urandom_range(0, 999));  // small negative
      default: begin
        r = $urandom_range(0, 63);
        v = (64'd1 << r) - 64'($urandom_range(0, 1));
      end
    endcase
    rq.value = v;
    return rq;
  endfunction

  // Present one item, idling first at random; expectations are queued once req_stall is low again.
  task automatic send_item(input ita_pkg::req_t rq, input row_kind_t kind,
                           input string txt);
    ita_pkg::rsp_t c;
    while (!calm && $urandom_range(0, 99) < 33) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    case (kind)
      ROW_TEXT:  queue_text(txt);
      ROW_ERROR: begin
        c = '{char_code: ita_pkg::CharNull, last: 1'b1, radix_error: 1'b1};
        pending_chars.push_back(c);
      end
      default:   predict_chars(rq);
    endcase
  endtask

  // Drop valid and wait until every owed character has come out.
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Compare each accepted character with the oldest one owed.
  always @(posedge clk) begin : check_chars
    ita_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_chars.size() == 0) begin
        report_fail($sformatf("unexpected char %h last %b err %b",
                              rsp.char_code, rsp.last, rsp.radix_error));
      end else begin
        want = pending_chars.pop_front();
        if (rsp.char_code !== want.char_code || rsp.last !== want.last ||
            rsp.radix_error !== want.radix_error) begin
          report_fail($sformatf("char %h/%h last %b/%b err %b/%b (expected/actual)",
                                want.char_code, rsp.char_code, want.last, rsp.last,
                                want.radix_error, rsp.radix_error));
        end
      end
    end
  end

  initial begin
    // Directed table: extremes, every radix class, sign handling, bad radixes
    add_row(ROW_TEXT,  1'b0, 64'd0, 5'd10, "0");
    add_row(ROW_TEXT,  1'b1, 64'd0, 5'd2, "0");
    add_row(ROW_TEXT,  1'b0, 64'hffff_ffff_ffff_ffff, 5'd16, "ffffffffffffffff");
    add_row(ROW_TEXT,  1'b0, 64'hffff_ffff_ffff_ffff, 5'd2,
            "1111111111111111111111111111111111111111111111111111111111111111");
    add_row(ROW_TEXT,  1'b0, 64'hffff_ffff_ffff_ffff, 5'd10, "18446744073709551615");
    // most negative decimal keeps its full magnitude
    add_row(ROW_TEXT,  1'b1, 64'h8000_0000_0000_0000, 5'd10, "-9223372036854775808");
    add_row(ROW_TEXT,  1'b0, 64'h8000_0000_0000_0000, 5'd10, "9223372036854775808");
    add_row(ROW_TEXT,  1'b1, 64'h7fff_ffff_ffff_ffff, 5'd10, "9223372036854775807");
    add_row(ROW_TEXT,  1'b1, 64'hffff_ffff_ffff_ffff, 5'd10, "-1");
    // signed but not decimal: raw bit pattern
    add_row(ROW_TEXT,  1'b1, 64'hffff_ffff_ffff_ffff, 5'd16, "ffffffffffffffff");
    add_row(ROW_TEXT,  1'b1, 64'd42, 5'd10, "42");
    add_row(ROW_TEXT,  1'b0, 64'h0123_4567_89ab_cdef, 5'd16, "123456789abcdef");
    add_row(ROW_TEXT,  1'b0, 64'd15, 5'd16, "f");
    add_row(ROW_ERROR, 1'b0, 64'd0, 5'd0, "");
    add_row(ROW_ERROR, 1'b1, 64'hffff_ffff_ffff_ffff, 5'd1, "");
    add_row(ROW_ERROR, 1'b0, 64'd5, 5'd17, "");
    add_row(ROW_ERROR, 1'b1, 64'h8000_0000_0000_0000, 5'd31, "");
    add_row(ROW_MODEL, 1'b1, 64'h8000_0000_0000_0000, 5'd2, "");
    add_row(ROW_MODEL, 1'b1, 64'hfedc_ba98_7654_3210, 5'd8, "");
    add_row(ROW_MODEL, 1'b0, 64'hdead_beef_cafe_f00d, 5'd3, "");
    add_row(ROW_MODEL, 1'b0, 64'h0000_0000_0012_d687, 5'd7, "");
    add_row(ROW_MODEL, 1'b1, 64'h5555_aaaa_3333_cccc, 5'd9, "");
    add_row(ROW_MODEL, 1'b0, 64'h0000_00ff_ffff_ffff, 5'd11, "");
    add_row(ROW_MODEL, 1'b1, 64'hc000_0000_0000_0001, 5'd13, "");
    add_row(ROW_MODEL, 1'b0, 64'h1234_5678_9abc_def0, 5'd15, "");

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].rq, dir_rows[i].kind, dir_rows[i].txt);
    hold_until_drained();

    for (int n = 0; n < RandomItems; n++) begin
      calm <= (n >= 120 && n < 200);
      // sender holds off once mid-run until the converter has emptied out
      if (n == 200) hold_until_drained();
      send_item(make_req(), ROW_MODEL, "");
    end

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    if (pending_chars.size() != 0) report_fail("characters still owed at end of run");

    if (fail_count == 0) begin
      $display("** integer_to_ascii_radix_top: PASSED **");
    end else begin
      $display("** integer_to_ascii_radix_top: FAILED **");
    end
    $finish;
  end

endmodule
